@@ rtl/stt_pkg.sv @@
`default_nettype none
package stt_pkg;

    // default widths of position and length fields
    localparam int POSITION_BITS_DEF = 24;
    localparam int LENGTH_BITS_DEF   = 16;

    // result queue between scanner and output side
    localparam int QUEUE_DEPTH = 4;

    localparam int KW_COUNT = 12;
    localparam logic [KW_COUNT-1:0] KW_ALL = '1;

    // token kinds
    localparam logic [4:0] K_END      = 5'd0;
    localparam logic [4:0] K_LBRACE   = 5'd1;
    localparam logic [4:0] K_RBRACE   = 5'd2;
    localparam logic [4:0] K_LPAREN   = 5'd3;
    localparam logic [4:0] K_RPAREN   = 5'd4;
    localparam logic [4:0] K_LBRACKET = 5'd5;
    localparam logic [4:0] K_RBRACKET = 5'd6;
    localparam logic [4:0] K_COMMA    = 5'd7;
    localparam logic [4:0] K_SEMI     = 5'd8;
    localparam logic [4:0] K_PLUS     = 5'd9;
    localparam logic [4:0] K_STAR     = 5'd10;
    localparam logic [4:0] K_MINUS    = 5'd11;
    localparam logic [4:0] K_SLASH    = 5'd12;
    localparam logic [4:0] K_GT      = 5'd15;
    localparam logic [4:0] K_LT      = 5'd16;
    localparam logic [4:0] K_ASSIGN  = 5'd13;
    localparam logic [4:0] K_ISEQ    = 5'd14;
    localparam logic [4:0] K_STRING  = 5'd17;
    localparam logic [4:0] K_NUMBER  = 5'd18;
    localparam logic [4:0] K_IDENT   = 5'd19;
    localparam logic [4:0] K_TYPE    = 5'd20;
    localparam logic [4:0] K_KW0     = 5'd21;
    localparam logic [4:0] K_UNKNOWN = 5'd30;
    localparam int         KW_TYPE_FIRST = 9;

    // write strobes from scanner into queue
    typedef struct packed {
        logic wr0;
        logic wr1;
    } t_push;

    // keyword text, left aligned, space padded to 16 characters
    function automatic logic [127:0] kw_text(input logic [3:0] k);
        logic [127:0] t;
        case (k)
            4'd0:    t = "intrinsic.scan  ";
            4'd1:    t = "intrinsic.sqrt  ";
            4'd2:    t = "intrinsic.print ";
            4'd3:    t = "intrinsic.concat";
            4'd4:    t = "intrinsic.substr";
            4'd5:    t = "function        ";
            4'd6:    t = "if              ";
            4'd7:    t = "for             ";
            4'd8:    t = "return          ";
            4'd9:    t = "int             ";
            4'd10:   t = "float           ";
            4'd11:   t = "string          ";
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] idx);
        logic [127:0] t;
        t = kw_text(k);
        return t[8*(15-int'(idx)) +: 8];
    endfunction

    function automatic logic [4:0] kw_len(input logic [3:0] k);
        logic [4:0] n;
        case (k)
            4'd0, 4'd1: n = 5'd14;
            4'd2:       n = 5'd15;
            4'd3, 4'd4: n = 5'd16;
            4'd5:       n = 5'd8;
            4'd6:       n = 5'd2;
            4'd7, 4'd9: n = 5'd3;
            4'd8, 4'd11: n = 5'd6;
            4'd10:      n = 5'd5;
            default:    n = 5'd0;
        endcase
        return n;
    endfunction

    // single character tokens; zero when the byte is none of them
    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            8'h7B:   k = K_LBRACE;    // {
            8'h7D:   k = K_RBRACE;    // }
            8'h28:   k = K_LPAREN;    // (
            8'h29:   k = K_RPAREN;    // )
            8'h5B:   k = K_LBRACKET;  // [
            8'h5D:   k = K_RBRACKET;  // ]
            8'h2C:   k = K_COMMA;     // ,
            8'h3B:   k = K_SEMI;      // ;
            8'h2B:   k = K_PLUS;      // +
            8'h2A:   k = K_STAR;      // *
            8'h2D:   k = K_MINUS;     // -
            8'h2F:   k = K_SLASH;     // /
            8'h3E:   k = K_GT;
            8'h3C:   k = K_LT;
            default: k = K_END;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

@@ rtl/stt_scan.sv @@
`default_nettype none
module stt_scan #(
    parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = stt_pkg::LENGTH_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [7:0]               i_char_code,
    input  logic                     i_end_of_text,
    output stt_pkg::t_push           o_push,
    output logic [4:0]               o_kind0,
    output logic [POSITION_BITS-1:0] o_start0,
    output logic [LENGTH_BITS-1:0]   o_len0,
    output logic [4:0]               o_kind1,
    output logic [POSITION_BITS-1:0] o_start1,
    output logic [LENGTH_BITS-1:0]   o_len1
);
    import stt_pkg::*;

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_EQ   = 3'd1;
    localparam logic [2:0] MODE_STR  = 3'd2;
    localparam logic [2:0] MODE_NUM  = 3'd3;
    localparam logic [2:0] MODE_ID   = 3'd4;
    localparam logic [2:0] MODE_HALT = 3'd5;
    localparam logic [2:0] MODE_DONE = 3'd6;

    localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] LEN_TWO = LENGTH_BITS'(2);

    logic [2:0]               r_mode,   n_mode;
    logic [POSITION_BITS-1:0] r_pstart, n_pstart;
    logic [LENGTH_BITS-1:0]   r_plen,   n_plen;
    logic [KW_COUNT-1:0]      r_kwv,    n_kwv;
    logic [POSITION_BITS-1:0] r_pos,    n_pos;

    // character classes
    logic c_space, c_digit, c_alpha, c_dot, c_quote, c_eq;
    logic [4:0] c_punct;

    always_comb begin
        c_space = (i_char_code == 8'd32) || (i_char_code >= 8'd9 && i_char_code <= 8'd13);
        c_digit = (i_char_code >= 8'h30) && (i_char_code <= 8'h39);
        c_alpha = ((i_char_code >= 8'h41) && (i_char_code <= 8'h5A)) ||
                  ((i_char_code >= 8'h61) && (i_char_code <= 8'h7A));
        c_dot   = (i_char_code == 8'h2E);
        c_quote = (i_char_code == 8'h22);
        c_eq    = (i_char_code == 8'h3D);
        c_punct = punct_kind(i_char_code);
    end

    // keyword prefix match: continuing an identifier, and starting one
    logic [KW_COUNT-1:0] m_cont, m_first;

    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            m_cont[k] = r_kwv[k] &&
                        (r_plen < LENGTH_BITS'(kw_len(4'(k)))) &&
                        (kw_char(4'(k), r_plen[3:0]) == i_char_code);
            m_first[k] = (kw_char(4'(k), 4'd0) == i_char_code);
        end
    end

    // identifier kind from the match vector, first keyword wins
    logic [4:0] id_kind;

    always_comb begin
        id_kind = K_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (r_kwv[k] && (r_plen == LENGTH_BITS'(kw_len(4'(k))))) begin
                id_kind = (k < KW_TYPE_FIRST) ? 5'(int'(K_KW0) + k) : K_TYPE;
            end
        end
    end

    // flush of the pending token
    logic                   f_vld;
    logic [4:0]             f_kind;
    logic [LENGTH_BITS-1:0] f_len;

    always_comb begin
        f_vld  = 1'b1;
        f_kind = K_IDENT;
        f_len  = r_plen;
        unique case (r_mode)
            MODE_EQ: begin
                f_kind = K_ASSIGN;
                f_len  = LEN_ONE;
            end
            MODE_STR: f_kind = K_STRING;
            MODE_NUM: f_kind = K_NUMBER;
            MODE_ID:  f_kind = id_kind;
            default:  f_vld  = 1'b0;
        endcase
    end

    // a character seen between tokens
    logic                   s_emit, s_pend;
    logic [4:0]             s_kind;
    logic [2:0]             s_mode;
    logic [LENGTH_BITS-1:0] s_plen;

    always_comb begin
        s_emit = 1'b0;
        s_pend = 1'b0;
        s_kind = K_UNKNOWN;
        s_mode = MODE_IDLE;
        s_plen = '0;
        if (c_space) begin
            s_mode = MODE_IDLE;
        end else if (c_punct != K_END) begin
            s_emit = 1'b1;
            s_kind = c_punct;
        end else if (c_eq) begin
            s_pend = 1'b1;
            s_mode = MODE_EQ;
        end else if (c_quote) begin
            s_pend = 1'b1;
            s_mode = MODE_STR;
        end else if (c_digit) begin
            s_pend = 1'b1;
            s_mode = MODE_NUM;
            s_plen = LEN_ONE;
        end else if (c_alpha) begin
            s_pend = 1'b1;
            s_mode = MODE_ID;
            s_plen = LEN_ONE;
        end else begin
            s_emit = 1'b1;
            s_mode = MODE_HALT;
        end
    end

    // scanner next state and up to two results
    logic                     a_vld, b_vld;
    logic [4:0]               a_kind, b_kind;
    logic [POSITION_BITS-1:0] a_start, b_start;
    logic [LENGTH_BITS-1:0]   a_len, b_len;
    logic                     restart;
    logic [LENGTH_BITS-1:0]   g_plen;

    always_comb begin
        g_plen   = (r_plen == '1) ? r_plen : r_plen + 1'b1;
        n_mode   = r_mode;
        n_pstart = r_pstart;
        n_plen   = r_plen;
        n_kwv    = r_kwv;
        n_pos    = r_pos;
        a_vld    = 1'b0;
        a_kind   = f_kind;
        a_start  = r_pstart;
        a_len    = f_len;
        b_vld    = 1'b0;
        b_kind   = s_kind;
        b_start  = r_pos;
        b_len    = LEN_ONE;
        restart  = 1'b0;
        if (i_accept && (r_mode != MODE_HALT) && (r_mode != MODE_DONE)) begin
            if (i_end_of_text) begin
                a_vld  = f_vld;
                b_vld  = 1'b1;
                b_kind = K_END;
                b_len  = '0;
                n_mode = MODE_DONE;
            end else begin
                n_pos = r_pos + 1'b1;
                unique case (r_mode)
                    MODE_EQ: begin
                        if (c_eq) begin
                            a_vld  = 1'b1;
                            a_kind = K_ISEQ;
                            a_len  = LEN_TWO;
                            n_mode = MODE_IDLE;
                        end else begin
                            restart = 1'b1;
                        end
                    end
                    MODE_STR: begin
                        if (c_quote) begin
                            a_vld  = 1'b1;
                            n_mode = MODE_IDLE;
                        end else begin
                            n_plen = g_plen;
                        end
                    end
                    MODE_NUM: begin
                        if (c_digit || c_dot) begin
                            n_plen = g_plen;
                        end else begin
                            restart = 1'b1;
                        end
                    end
                    MODE_ID: begin
                        if (c_alpha || c_digit || c_dot) begin
                            n_kwv  = m_cont;
                            n_plen = g_plen;
                        end else begin
                            restart = 1'b1;
                        end
                    end
                    default: restart = 1'b1;
                endcase
                // close any pending token, then start on this character
                if (restart) begin
                    a_vld  = f_vld;
                    b_vld  = s_emit;
                    n_mode = s_mode;
                    if (s_pend) begin
                        n_pstart = r_pos;
                        n_plen   = s_plen;
                    end
                    if (s_mode == MODE_ID) begin
                        n_kwv = m_first;
                    end
                end
            end
        end
    end

    // pack results so the first one always lands in slot 0
    always_comb begin
        o_push.wr0 = a_vld | b_vld;
        o_push.wr1 = a_vld & b_vld;
        o_kind0    = a_vld ? a_kind  : b_kind;
        o_start0   = a_vld ? a_start : b_start;
        o_len0     = a_vld ? a_len   : b_len;
        o_kind1    = b_kind;
        o_start1   = b_start;
        o_len1     = b_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_pstart <= '0;
            r_plen   <= '0;
            r_kwv    <= KW_ALL;
            r_pos    <= '0;
        end else begin
            r_mode   <= n_mode;
            r_pstart <= n_pstart;
            r_plen   <= n_plen;
            r_kwv    <= n_kwv;
            r_pos    <= n_pos;
        end
    end

    // two results only ever come as a pair filling both slots
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.wr1 |-> o_push.wr0)
        else $error("second result without a first");

    // a halted scanner stays halted and silent
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_HALT) |=> (r_mode == MODE_HALT) && !o_push.wr0)
        else $error("scanner left halt");

    // end of text in an active mode finishes the stream
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_end_of_text && (r_mode != MODE_HALT) && (r_mode != MODE_DONE))
        |=> (r_mode == MODE_DONE))
        else $error("end of text did not finish");

    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_DONE) |-> !o_push.wr0 && $stable(r_pos))
        else $error("result after end");

endmodule
`default_nettype wire

@@ rtl/stt_queue.sv @@
`default_nettype none
module stt_queue #(
    parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = stt_pkg::LENGTH_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  stt_pkg::t_push           i_push,
    input  logic [4:0]               i_kind0,
    input  logic [POSITION_BITS-1:0] i_start0,
    input  logic [LENGTH_BITS-1:0]   i_len0,
    input  logic [4:0]               i_kind1,
    input  logic [POSITION_BITS-1:0] i_start1,
    input  logic [LENGTH_BITS-1:0]   i_len1,
    output logic                     o_full,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [4:0]               o_token_kind,
    output logic [POSITION_BITS-1:0] o_token_start,
    output logic [LENGTH_BITS-1:0]   o_token_length,
    output logic                     o_last_of_run
);
    import stt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [4:0]               r_kind  [QUEUE_DEPTH];
    logic [POSITION_BITS-1:0] r_start [QUEUE_DEPTH];
    logic [LENGTH_BITS-1:0]   r_len   [QUEUE_DEPTH];
    logic                     r_last  [QUEUE_DEPTH];
    logic [PTR_W-1:0]         r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;
    // room for a full pair is needed before the next request is taken
    assign o_full  = (r_count > CNT_W'(QUEUE_DEPTH - 2));

    assign o_token_kind   = r_kind[r_rd];
    assign o_token_start  = r_start[r_rd];
    assign o_token_length = r_len[r_rd];
    assign o_last_of_run  = r_last[r_rd];

    always_comb begin
        n_wr    = r_wr + PTR_W'({i_push.wr1, i_push.wr0} == 2'b11 ? 2 : (i_push.wr0 ? 1 : 0));
        n_rd    = r_rd + PTR_W'(pop);
        n_count = r_count + CNT_W'(i_push.wr0) + CNT_W'(i_push.wr1) - CNT_W'(pop);
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.wr0) begin
            r_kind[r_wr]  <= i_kind0;
            r_start[r_wr] <= i_start0;
            r_len[r_wr]   <= i_len0;
            r_last[r_wr]  <= !i_push.wr1;
        end
        if (i_push.wr1) begin
            r_kind[r_wr + 1'b1]  <= i_kind1;
            r_start[r_wr + 1'b1] <= i_start1;
            r_len[r_wr + 1'b1]   <= i_len1;
            r_last[r_wr + 1'b1]  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue overflow");

    a_pair_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.wr1 |-> (r_count <= CNT_W'(QUEUE_DEPTH - 2)))
        else $error("pair written without room");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_push.wr0) |=> (r_count == $past(r_count) - 1'b1))
        else $error("count lost track of a read");

endmodule
`default_nettype wire

@@ rtl/source_text_tokenizer.sv @@
`default_nettype none
// Channel  Direction  Handshake          Payload
// input    in         i_valid / o_stall  i_char_code, i_end_of_text
// output   out        o_valid / i_stall  o_token_kind, o_token_start, o_token_length,
//                                        o_last_of_run
//
// One request per cycle while o_stall is low; the scanner decides each character in the cycle it is taken.
// A request gives zero, one or two tokens; the four-entry result queue drains one a cycle while i_stall is low.
// o_stall rises when the queue has room for fewer than two tokens.
// Tokens are written into the result queue registers when the request is taken and are presented from there.
// Reset is synchronous, active low; no clearing pass is needed.
module source_text_tokenizer #(
    parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = stt_pkg::LENGTH_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [7:0]               i_char_code,
    input  logic                     i_end_of_text,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [4:0]               o_token_kind,
    output logic [POSITION_BITS-1:0] o_token_start,
    output logic [LENGTH_BITS-1:0]   o_token_length,
    output logic                     o_last_of_run
);
    import stt_pkg::*;

    t_push                    push;
    logic                     accept;
    logic                     full;
    logic [4:0]               kind0, kind1;
    logic [POSITION_BITS-1:0] start0, start1;
    logic [LENGTH_BITS-1:0]   len0, len1;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    // front: classify characters and build tokens
    stt_scan #(
        .POSITION_BITS(POSITION_BITS),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_char_code  (i_char_code),
        .i_end_of_text(i_end_of_text),
        .o_push       (push),
        .o_kind0      (kind0),
        .o_start0     (start0),
        .o_len0       (len0),
        .o_kind1      (kind1),
        .o_start1     (start1),
        .o_len1       (len1)
    );

    // back: queue and output
    stt_queue #(
        .POSITION_BITS(POSITION_BITS),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_kind0       (kind0),
        .i_start0      (start0),
        .i_len0        (len0),
        .i_kind1       (kind1),
        .i_start1      (start1),
        .i_len1        (len1),
        .o_full        (full),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_token_kind  (o_token_kind),
        .o_token_start (o_token_start),
        .o_token_length(o_token_length),
        .o_last_of_run (o_last_of_run)
    );

endmodule
`default_nettype wire
